FILE: design/odp_pkg.sv
// Shared types, widths and codes for the obstacle axis distance potential block.
`default_nettype none
package odp_pkg;

  localparam int COST_W         = 8;
  localparam int POS_W          = 8;
  localparam int DIM_W          = 9;
  localparam int POT_W          = 17;
  localparam int DIST_SUM_W     = 9;
  localparam int STORE_CMP_W    = 13;
  localparam int ADDR_CALC_W    = 24;
  localparam int AXIS_LIMIT     = 256;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_FREE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 2'd2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;
  localparam logic [DIM_W-1:0] DIM_ONE   = 9'd1;
  localparam logic [POT_W-1:0] POT_ALL_ONES = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_CALC
  } state_t;

  // per-axis scanner control, one sample per cycle
  typedef struct packed {
    logic             clear;
    logic             sample;
    logic [POS_W-1:0] pos;
  } scan_ctl_t;

endpackage
`default_nettype wire

FILE: design/odp_cost_mem.sv
// Cost grid memory: one write port, two registered read ports.
`default_nettype none
module odp_cost_mem
  import odp_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  parameter int AW    = $clog2(DEF_MAX_WIDTH * DEF_MAX_HEIGHT)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [COST_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr_a,
  input  wire logic [AW-1:0]     raddr_b,
  output logic      [COST_W-1:0] rdata_a,
  output logic      [COST_W-1:0] rdata_b
);

  logic [COST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

FILE: design/odp_axis_scan.sv
// Nearest free cell tracker along one axis, one sample per cycle.
`default_nettype none
module odp_axis_scan
  import odp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire scan_ctl_t         ctl,
  input  wire logic [POS_W-1:0]  target,
  input  wire logic [COST_W-1:0] cost,
  input  wire logic [COST_W-1:0] threshold,
  output logic                   found,
  output logic      [POS_W-1:0]  near_dist
);

  logic             found_next;
  logic [POS_W-1:0] near_dist_next;
  logic [POS_W-1:0] d;

  always_comb begin
    d = (ctl.pos >= target) ? (ctl.pos - target) : (target - ctl.pos);
    found_next     = found;
    near_dist_next = near_dist;
    if (ctl.clear) begin
      found_next     = 1'b0;
      near_dist_next = '0;
    end else if (ctl.sample && (cost <= threshold) && (!found || (d < near_dist))) begin
      found_next     = 1'b1;
      near_dist_next = d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      near_dist <= '0;
    end else begin
      found     <= found_next;
      near_dist <= near_dist_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/obstacle_axis_distance_potential.sv
// Top level: request decode, row/column scan sequencer and potential output.
//
//  channel   ports                                           handshake
//  request   action cell_x cell_y cell_cost                  start & !busy
//  result    potential unreachable                           done, one cycle
//  config    cfg_index cfg_data                              cfg_we
//
// A write never raises busy. A read outside the grid in use gives its result in
// the next cycle without raising busy. Any other read scans its row and column
// together, one cell per axis per cycle through the two read ports of the cost
// memory, then stays busy through ST_LAST and ST_CALC; the result is registered
// from ST_CALC. Sync reset clears control, not the result or the cost memory.
// The receiver cannot stall; done is a one-cycle strobe.
`default_nettype none
module obstacle_axis_distance_potential
  import odp_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  action,
  input  wire logic [POS_W-1:0]      cell_x,
  input  wire logic [POS_W-1:0]      cell_y,
  input  wire logic [COST_W-1:0]     cell_cost,
  output logic                       done,
  output logic      [POT_W-1:0]      potential,
  output logic                       unreachable,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [DIM_W-1:0] LIM_W =
    DIM_W'((MAX_WIDTH < AXIS_LIMIT) ? MAX_WIDTH : AXIS_LIMIT);
  localparam logic [DIM_W-1:0] LIM_H =
    DIM_W'((MAX_HEIGHT < AXIS_LIMIT) ? MAX_HEIGHT : AXIS_LIMIT);

  // configuration
  logic [COST_W-1:0] free_threshold;
  logic [DIM_W-1:0]  grid_width;
  logic [DIM_W-1:0]  grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_threshold <= '0;
      grid_width     <= DIM_RESET;
      grid_height    <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FREE_THRESHOLD: free_threshold <= cfg_data[COST_W-1:0];
        CFG_GRID_WIDTH:     grid_width     <= cfg_data;
        CFG_GRID_HEIGHT:    grid_height    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_use;
  logic [DIM_W-1:0] h_use;
  logic [DIM_W-1:0] scan_len;

  always_comb begin
    w_use = (grid_width == '0) ? DIM_ONE : ((grid_width > LIM_W) ? LIM_W : grid_width);
    h_use = (grid_height == '0) ? DIM_ONE : ((grid_height > LIM_H) ? LIM_H : grid_height);
    scan_len = (w_use > h_use) ? w_use : h_use;
  end

  // request decode
  logic accept;
  logic in_store;
  logic in_grid;
  logic mem_we;
  logic [AW-1:0] waddr;

  assign accept   = start && !busy;
  assign in_store = ({5'd0, cell_x} < STORE_CMP_W'(MAX_WIDTH)) &&
                    ({5'd0, cell_y} < STORE_CMP_W'(MAX_HEIGHT));
  assign in_grid  = ({1'b0, cell_x} < w_use) && ({1'b0, cell_y} < h_use);
  assign mem_we   = accept && (action == ACT_WRITE) && in_store;
  assign waddr    = AW'(ADDR_CALC_W'(cell_y) * ADDR_CALC_W'(MAX_WIDTH) +
                        ADDR_CALC_W'(cell_x));

  // sequencer
  state_t state;
  state_t state_next;
  logic [POS_W-1:0] req_x;
  logic [POS_W-1:0] req_y;
  logic [POS_W-1:0] p;
  logic [POS_W-1:0] p_d;
  logic             row_vld;
  logic             col_vld;
  logic             scan_last;
  logic             scan_start;
  logic             scan_issue;
  logic             calc;

  assign scan_start = accept && (action == ACT_READ) && in_grid;
  assign scan_last  = ({1'b0, p} == (scan_len - DIM_ONE));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (scan_start) state_next = ST_SCAN;
      ST_SCAN: if (scan_last)  state_next = ST_LAST;
      ST_LAST: state_next = ST_CALC;
      ST_CALC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    scan_issue = 1'b0;
    calc       = 1'b0;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: scan_issue = 1'b1;
      ST_LAST: ;
      ST_CALC: calc = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      p       <= '0;
      row_vld <= 1'b0;
      col_vld <= 1'b0;
    end else begin
      state   <= state_next;
      row_vld <= scan_issue && ({1'b0, p} < w_use);
      col_vld <= scan_issue && ({1'b0, p} < h_use);
      if (scan_start) begin
        p <= '0;
      end else if (scan_issue) begin
        p <= p + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    p_d <= p;
    if (scan_start) begin
      req_x <= cell_x;
      req_y <= cell_y;
    end
  end

  // memory and scanners
  logic [AW-1:0]     row_addr;
  logic [AW-1:0]     col_addr;
  logic [COST_W-1:0] row_data;
  logic [COST_W-1:0] col_data;

  assign row_addr = AW'(ADDR_CALC_W'(req_y) * ADDR_CALC_W'(MAX_WIDTH) + ADDR_CALC_W'(p));
  assign col_addr = AW'(ADDR_CALC_W'(p) * ADDR_CALC_W'(MAX_WIDTH) + ADDR_CALC_W'(req_x));

  odp_cost_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (waddr),
    .wdata   (cell_cost),
    .raddr_a (row_addr),
    .raddr_b (col_addr),
    .rdata_a (row_data),
    .rdata_b (col_data)
  );

  scan_ctl_t row_ctl;
  scan_ctl_t col_ctl;
  logic             row_found;
  logic             col_found;
  logic [POS_W-1:0] row_dist;
  logic [POS_W-1:0] col_dist;

  always_comb begin
    row_ctl.clear  = scan_start;
    row_ctl.sample = row_vld;
    row_ctl.pos    = p_d;
    col_ctl.clear  = scan_start;
    col_ctl.sample = col_vld;
    col_ctl.pos    = p_d;
  end

  odp_axis_scan u_row (
    .clk       (clk),
    .rst       (rst),
    .ctl       (row_ctl),
    .target    (req_x),
    .cost      (row_data),
    .threshold (free_threshold),
    .found     (row_found),
    .near_dist (row_dist)
  );

  odp_axis_scan u_col (
    .clk       (clk),
    .rst       (rst),
    .ctl       (col_ctl),
    .target    (req_y),
    .cost      (col_data),
    .threshold (free_threshold),
    .found     (col_found),
    .near_dist (col_dist)
  );

  // the cell's own cost passes by on the row scan
  logic [COST_W-1:0] own_cost;

  always_ff @(posedge clk) begin
    if (row_vld && (p_d == req_x)) begin
      own_cost <= row_data;
    end
  end

  // result
  logic [DIST_SUM_W-1:0] dist_sum;
  logic [POT_W-1:0]      product;
  logic                  out_of_grid_rd;

  assign dist_sum       = {1'b0, row_dist} + {1'b0, col_dist};
  assign product        = POT_W'(dist_sum) * POT_W'(own_cost);
  assign out_of_grid_rd = accept && (action == ACT_READ) && !in_grid;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= out_of_grid_rd || calc;
    end
  end

  always_ff @(posedge clk) begin
    if (out_of_grid_rd) begin
      potential   <= '0;
      unreachable <= 1'b0;
    end else if (calc) begin
      if (!(row_found && col_found)) begin
        potential   <= POT_ALL_ONES;
        unreachable <= 1'b1;
      end else begin
        potential   <= product;
        unreachable <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/odp_checker.sv
// Port-level assertions for the potential block, bound to the top level.
`default_nettype none
module odp_checker
  import odp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             action,
  input wire logic             done,
  input wire logic [POT_W-1:0] potential,
  input wire logic             unreachable
);

  // a read either answers at once or holds the block busy
  a_read_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_READ)) |=> (done || busy))
    else $error("read request neither answered nor started a scan");

  // a write never occupies the block
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_WRITE)) |=> !busy)
    else $error("write request raised busy");

  // the end of a scan always delivers its result
  a_scan_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("scan ended without a result");

  a_unreach_sat: assert property (@(posedge clk) disable iff (rst)
    (done && unreachable) |-> (potential == POT_ALL_ONES))
    else $error("unreachable result not saturated");

endmodule

bind obstacle_axis_distance_potential odp_checker u_odp_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .action      (action),
  .done        (done),
  .potential   (potential),
  .unreachable (unreachable)
);
`default_nettype wire

FILE: verif/tb.sv
// Testbench for the obstacle axis distance potential block: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb;
  import odp_pkg::*;

  localparam int LINE       = DEF_MAX_WIDTH;
  localparam int CYCLE_CAP  = 3000000;
  localparam int DRAIN_WAIT = 300;

  typedef struct packed {
    logic [POT_W-1:0] pot;
    logic             unr;
  } potential_t;

  // Tracks the cost grid and registers, predicts each read's potential in order.
  class potential_scoreboard;
    logic [COST_W-1:0] cost_mem [0:LINE*DEF_MAX_HEIGHT-1];
    logic [COST_W-1:0] threshold;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    potential_t        expected_q [$];
    int                errors;

    function new();
      threshold  = '0;
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      errors     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FREE_THRESHOLD: threshold = val[COST_W-1:0];
        CFG_GRID_WIDTH:     width_reg = val;
        CFG_GRID_HEIGHT:    height_reg = val;
        default: ;
      endcase
    endfunction

    function int clamp_dim(logic [DIM_W-1:0] v, int max_dim);
      int d;
      d = int'(v);
      if (d == 0) d = 1;
      if (d > AXIS_LIMIT) d = AXIS_LIMIT;
      if (d > max_dim) d = max_dim;
      return d;
    endfunction

    function int eff_width();
      return clamp_dim(width_reg, DEF_MAX_WIDTH);
    endfunction

    function int eff_height();
      return clamp_dim(height_reg, DEF_MAX_HEIGHT);
    endfunction

    // nearest free cell along a row (fixed = row) or a column (fixed = column)
    function void scan_line(bit along_row, int fixed, int len, int pos,
                            output bit found, output int near_dist);
      logic [COST_W-1:0] c;
      int d;
      found     = 1'b0;
      near_dist = 0;
      for (int p = 0; p < len; p++) begin
        c = along_row ? cost_mem[fixed*LINE + p] : cost_mem[p*LINE + fixed];
        if (c <= threshold) begin
          d = (p >= pos) ? p - pos : pos - p;
          if (!found || d < near_dist) begin
            near_dist = d;
            found     = 1'b1;
          end
        end
      end
    endfunction

    function void note_request(logic act, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                               logic [COST_W-1:0] cost);
      int w, h, dr, dc, prod;
      bit row_ok, col_ok;
      potential_t r;
      if (act == ACT_WRITE) begin
        cost_mem[int'(y)*LINE + int'(x)] = cost;
        return;
      end
      w = eff_width();
      h = eff_height();
      if (int'(x) >= w || int'(y) >= h) begin
        r.pot = '0;
        r.unr = 1'b0;
      end else begin
        scan_line(1'b1, int'(y), w, int'(x), row_ok, dr);
        scan_line(1'b0, int'(x), h, int'(y), col_ok, dc);
        if (!row_ok || !col_ok) begin
          r.pot = POT_ALL_ONES;
          r.unr = 1'b1;
        end else begin
          prod  = (dr + dc) * int'(cost_mem[int'(y)*LINE + int'(x)]);
          r.pot = prod[POT_W-1:0];
          r.unr = 1'b0;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [POT_W-1:0] pot, logic unr);
      potential_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: potential %0d unreachable %0d", $time, pot, unr);
        return;
      end
      exp_r = expected_q.pop_front();
      if (pot !== exp_r.pot) begin
        errors++;
        $display("%0t: potential mismatch: expected %0d actual %0d", $time, exp_r.pot, pot);
      end
      if (unr !== exp_r.unr) begin
        errors++;
        $display("%0t: unreachable mismatch: expected %0d actual %0d", $time, exp_r.unr, unr);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  action = ACT_WRITE;
  logic [POS_W-1:0]      cell_x = '0;
  logic [POS_W-1:0]      cell_y = '0;
  logic [COST_W-1:0]     cell_cost = '0;
  logic                  done;
  logic [POT_W-1:0]      potential;
  logic                  unreachable;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FREE_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  potential_scoreboard sb = new();
  bit written [0:LINE*DEF_MAX_HEIGHT-1];
  int idle_pct = 0;
  int cycle_count = 0;

  obstacle_axis_distance_potential dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_cost   (cell_cost),
    .done        (done),
    .potential   (potential),
    .unreachable (unreachable),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(potential, unreachable);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb failed");
      $finish;
    end
  end

  // Issue one request; start is left high so back-to-back requests keep it up.
  task automatic send(input logic act, input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                      input logic [COST_W-1:0] c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action    <= act;
    cell_x    <= x;
    cell_y    <= y;
    cell_cost <= c;
    start     <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(act, x, y, c);
    if (act == ACT_WRITE) written[int'(y)*LINE + int'(x)] = 1'b1;
  endtask

  task automatic wait_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [COST_W-1:0] pick_cost(int pfree);
    int thr;
    thr = int'(sb.threshold);
    if ($urandom_range(99) < pfree) return COST_W'($urandom_range(thr, 0));
    if (thr == 255) return COST_W'($urandom_range(255, 0));
    return COST_W'($urandom_range(255, thr + 1));
  endfunction

  // Write every never-written cell of the target's row and column before reading it.
  task automatic read_cell(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y, input int pfree);
    int w, h;
    w = sb.eff_width();
    h = sb.eff_height();
    if (int'(x) < w && int'(y) < h) begin
      for (int i = 0; i < w; i++)
        if (!written[int'(y)*LINE + i]) send(ACT_WRITE, POS_W'(i), y, pick_cost(pfree));
      for (int j = 0; j < h; j++)
        if (!written[j*LINE + int'(x)]) send(ACT_WRITE, x, POS_W'(j), pick_cost(pfree));
    end
    send(ACT_READ, x, y, COST_W'($urandom_range(255, 0)));
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] wid,
                           input logic [CFG_DATA_W-1:0] hgt);
    wait_results();
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FREE_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    sb.write_register(CFG_FREE_THRESHOLD, thr);
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= wid;
    @(posedge clk);
    sb.write_register(CFG_GRID_WIDTH, wid);
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_data  <= hgt;
    @(posedge clk);
    sb.write_register(CFG_GRID_HEIGHT, hgt);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] wid,
                           input logic [CFG_DATA_W-1:0] hgt, input int pct, input int count);
    int w, h, kind, pfree;
    logic [POS_W-1:0] x, y;
    configure(thr, wid, hgt);
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 2) wait_results();
      w    = sb.eff_width();
      h    = sb.eff_height();
      kind = $urandom_range(99);
      case ($urandom_range(3))
        0: pfree = 0;
        1: pfree = 3;
        2: pfree = 20;
        default: pfree = 60;
      endcase
      if (kind < 45) begin
        if ($urandom_range(9) == 0) begin
          x = POS_W'($urandom_range(255, 0));
          y = POS_W'($urandom_range(255, 0));
        end else begin
          x = POS_W'($urandom_range(w - 1, 0));
          y = POS_W'($urandom_range(h - 1, 0));
        end
        send(ACT_WRITE, x, y, pick_cost(40));
      end else if (kind < 90 || (w == AXIS_LIMIT && h == AXIS_LIMIT)) begin
        read_cell(POS_W'($urandom_range(w - 1, 0)), POS_W'($urandom_range(h - 1, 0)), pfree);
      end else begin
        // request outside the grid in use
        if (w < AXIS_LIMIT && (h == AXIS_LIMIT || $urandom_range(1) == 1)) begin
          x = POS_W'($urandom_range(255, w));
          y = POS_W'($urandom_range(255, 0));
        end else begin
          x = POS_W'($urandom_range(255, 0));
          y = POS_W'($urandom_range(255, h));
        end
        send(ACT_READ, x, y, COST_W'($urandom_range(255, 0)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // small 3x2 grid, threshold edge at 10
    configure(9'd10, 9'd3, 9'd2);
    idle_pct = 30;
    send(ACT_WRITE, 8'd0, 8'd0, 8'd0);
    send(ACT_WRITE, 8'd1, 8'd0, 8'd200);
    send(ACT_WRITE, 8'd2, 8'd0, 8'd255);
    send(ACT_WRITE, 8'd0, 8'd1, 8'd50);
    send(ACT_WRITE, 8'd1, 8'd1, 8'd11);
    send(ACT_WRITE, 8'd2, 8'd1, 8'd10);
    send(ACT_WRITE, 8'd255, 8'd255, 8'd255);
    read_cell(8'd2, 8'd0, 0);
    read_cell(8'd1, 8'd1, 0);
    read_cell(8'd0, 8'd0, 0);
    read_cell(8'd1, 8'd0, 0);
    read_cell(8'd0, 8'd1, 0);
    send(ACT_READ, 8'd3, 8'd0, 8'd255);
    send(ACT_READ, 8'd0, 8'd2, 8'd0);
    send(ACT_READ, 8'd255, 8'd255, 8'd170);

    // largest potential: free cells only at the far ends of row 255 and column 255
    configure(9'd0, 9'd256, 9'd256);
    send(ACT_WRITE, 8'd0, 8'd255, 8'd0);
    send(ACT_WRITE, 8'd255, 8'd0, 8'd0);
    read_cell(8'd255, 8'd255, 0);

    run_phase(9'd40, 9'd8, 9'd8, 0, 404);
    run_phase(9'd0, 9'd16, 9'd5, 79, 300);
    run_phase(9'd255, 9'd1, 9'd1, 0, 100);
    run_phase(9'd128, 9'd300, 9'd3, 30, 150);
    run_phase(9'd200, 9'd0, 9'd20, 79, 150);
    run_phase(9'd17, 9'd256, 9'd256, 30, 6);
    run_phase(9'h105, 9'd2, 9'd511, 0, 140);
    run_phase(9'd3, 9'd32, 9'd32, 79, 500);

    wait_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
